// ===== sv/cba_pkg.sv =====
// Shared types and constants of the contiguous block allocator.
`timescale 1ns / 1ps
package cba_pkg;

   localparam int BLOCK_COUNT_DEF = 4096;
   localparam int BLOCK_BYTES_DEF = 8;

   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 32;
   localparam int DIV_W    = 32;
   localparam int ROW_BITS = 8;
   localparam int ROW_SH   = $clog2(ROW_BITS);
   localparam int CSR_AW   = 3;

   localparam logic CSR_IDX_POOL_BASE = 1'b0;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } cba_op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_ADDR = 2'd2,
      STATUS_PAST_END = 2'd3
   } cba_status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV_SIZE,
      S_EVAL,
      S_DIV_ADDR,
      S_SCAN_RD,
      S_SCAN,
      S_MUL,
      S_ADD,
      S_RMW_RD,
      S_RMW_WR,
      S_DONE
   } cba_state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
   } cba_div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } cba_div_rsp_type;

   typedef struct packed {
      logic              valid;
      cba_status_type    status;
      logic [ADDR_W-1:0] address;
   } cba_result_type;

endpackage

// ===== sv/contiguous_block_allocator_unit.sv =====
// Top level of the contiguous block allocator: channels, register port, result register.
//
// First-fit allocator over a one-bit-per-block in-use map held in a RAM of
// 8-bit rows. Requests arrive on req_* (tuser = operation, 0 allocate,
// 1 free); one result per request leaves on rsp_*. The user must write
// pool_base at csr_* byte address 0 only while the block is idle (unchecked).
//
// After reset a clearing pass writes every map row to free, one row a
// cycle (ceil(BLOCK_COUNT/8) rows, 512 by default); req_tready stays low
// meanwhile. Configuration writes are taken during it.
//
// One request at a time. Sizes and free offsets are divided by the block
// size with a reciprocal multiply. An allocate scans the map a row at a
// time and stops at the first fitting run (up to 512 rows), then marks
// its rows by read-modify-write; a free clears its rows the same way.
// Zero-size or oversized allocates skip the scan, out-of-pool frees the
// offset division; misaligned, past-end or zero-size frees end after it.
// The next request is taken in the cycle after the result is loaded. If
// the receiver stalls, the next request is still taken and worked on,
// and waits only when its own result is ready and the register is still
// full.
`timescale 1ns / 1ps
module contiguous_block_allocator_unit #(
   parameter int BLOCK_COUNT = cba_pkg::BLOCK_COUNT_DEF,
   parameter int BLOCK_BYTES = cba_pkg::BLOCK_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [47:0]                req_tdata,   // size_bytes[15:0], free_address[47:16]
   input  logic                       req_tuser,   // operation[0]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [39:0]                rsp_tdata,   // status[1:0], alloc_address[33:2], zero
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [cba_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic [cba_pkg::ADDR_W-1:0] pool_base_ff, pool_base_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cba_pkg::cba_status_type    rsp_status_ff, rsp_status_in;
   logic [cba_pkg::ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic                       out_free;
   cba_pkg::cba_result_type    result;
   cba_pkg::cba_div_req_type   div_req;
   cba_pkg::cba_div_rsp_type   div_rsp;
   logic                       csr_sel_pool;

   cba_seq #(
      .BLOCK_COUNT(BLOCK_COUNT),
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_op   (cba_pkg::cba_op_type'(req_tuser)),
      .req_size (req_tdata[15:0]),
      .req_addr (req_tdata[47:16]),
      .pool_base(pool_base_ff),
      .out_free (out_free),
      .result   (result),
      .div_req  (div_req),
      .div_rsp  (div_rsp)
   );

   cba_div #(
      .BLOCK_BYTES(BLOCK_BYTES)
   ) u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign csr_pready   = 1'b1;
   assign csr_sel_pool = (csr_paddr[2] == cba_pkg::CSR_IDX_POOL_BASE);
   assign csr_prdata   = csr_sel_pool ? pool_base_ff : 32'd0;
   assign out_free     = !rsp_valid_ff || rsp_tready;

   always_comb begin
      pool_base_in  = pool_base_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel_pool) begin
         pool_base_in = csr_pwdata;
      end
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = result.status;
         rsp_addr_in   = result.address;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_base_ff <= pool_base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_addr_ff, rsp_status_ff};

endmodule

// ===== sv/cba_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                     wdata,
   output logic [WIDTH-1:0]                     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/cba_div.sv =====
// Block-size divider: reciprocal multiply, then remainder.
`timescale 1ns / 1ps
module cba_div #(
   parameter int BLOCK_BYTES = cba_pkg::BLOCK_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cba_pkg::cba_div_req_type div_req,
   output cba_pkg::cba_div_rsp_type div_rsp
);

   localparam int DW = cba_pkg::DIV_W;
   localparam int LW = $clog2(BLOCK_BYTES);
   localparam int SH = DW + LW;
   localparam int MW = DW + 1;
   localparam int PW = DW + MW;
   // ceil(2^SH / BLOCK_BYTES) gives an exact quotient for every DW-bit dividend
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
   localparam logic [MW-1:0] RECIP   = MW'(RECIP_L);
   localparam logic [DW-1:0] DIVISOR = DW'(BLOCK_BYTES);

   logic          mul_ff, mul_in;
   logic          sub_ff, sub_in;
   logic          done_ff, done_in;
   logic [DW-1:0] num_ff, num_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [PW-1:0] product;

   assign product = PW'(num_ff) * PW'(RECIP);

   always_comb begin
      mul_in  = 1'b0;
      sub_in  = 1'b0;
      done_in = 1'b0;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         num_in = div_req.dividend;
         mul_in = 1'b1;
      end
      if (mul_ff) begin
         quo_in = DW'(product >> SH);
         sub_in = 1'b1;
      end
      if (sub_ff) begin
         rem_in  = num_ff - (quo_ff * DIVISOR);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         sub_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         sub_ff  <= sub_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== sv/cba_seq.sv =====
// Allocator sequencer: map clearing, first-fit scan and row read-modify-write.
`timescale 1ns / 1ps
module cba_seq #(
   parameter int BLOCK_COUNT = cba_pkg::BLOCK_COUNT_DEF,
   parameter int BLOCK_BYTES = cba_pkg::BLOCK_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cba_pkg::cba_op_type               req_op,
   input  logic [cba_pkg::SIZE_W-1:0]        req_size,
   input  logic [cba_pkg::ADDR_W-1:0]        req_addr,
   input  logic [cba_pkg::ADDR_W-1:0]        pool_base,
   input  logic                              out_free,
   output cba_pkg::cba_result_type           result,
   output cba_pkg::cba_div_req_type          div_req,
   input  cba_pkg::cba_div_rsp_type          div_rsp
);

   localparam int RB     = cba_pkg::ROW_BITS;
   localparam int RS     = cba_pkg::ROW_SH;
   localparam int AW     = cba_pkg::ADDR_W;
   localparam int DW     = cba_pkg::DIV_W;
   localparam int CNT_W  = cba_pkg::SIZE_W;
   localparam int ROWS   = (BLOCK_COUNT + RB - 1) / RB;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int IDX_W  = ROW_AW + RS;
   localparam int XW     = IDX_W + 1;
   localparam int BLK_W  = $clog2(BLOCK_COUNT + 1);
   localparam int SW     = ((CNT_W > BLK_W) ? CNT_W : BLK_W) + 1;

   localparam logic [ROW_AW-1:0] LAST_ROW   = ROW_AW'(ROWS - 1);
   localparam logic [XW-1:0]     BLK_LIM_X  = XW'(BLOCK_COUNT);
   localparam logic [SW-1:0]     BLK_LIM_S  = SW'(BLOCK_COUNT);
   localparam logic [DW:0]       BLK_LIM_D  = (DW + 1)'(BLOCK_COUNT);
   localparam logic [AW-1:0]     POOL_BYTES = AW'(BLOCK_COUNT * BLOCK_BYTES);
   localparam logic [AW-1:0]     BB_A       = AW'(BLOCK_BYTES);

   cba_pkg::cba_state_type  state_ff, state_in;
   logic [ROW_AW-1:0]       row_ff, row_in;
   logic [ROW_AW-1:0]       last_row_ff, last_row_in;
   cba_pkg::cba_op_type     op_ff, op_in;
   logic [AW-1:0]           addr_ff, addr_in;
   logic [CNT_W-1:0]        need_ff, need_in;
   logic [CNT_W-1:0]        run_ff, run_in;
   logic [BLK_W-1:0]        start_ff, start_in;
   logic [BLK_W-1:0]        end_ff, end_in;
   logic [AW-1:0]           prod_ff, prod_in;
   cba_pkg::cba_status_type status_ff, status_in;
   logic [AW-1:0]           res_addr_ff, res_addr_in;

   logic                    ram_we;
   logic [ROW_AW-1:0]       ram_addr;
   logic [RB-1:0]           ram_wdata;
   logic [RB-1:0]           ram_rdata;

   logic [CNT_W-1:0]        scan_run;
   logic [BLK_W-1:0]        scan_start;
   logic                    scan_found;
   logic [IDX_W-1:0]        scan_idx;
   logic [IDX_W-1:0]        mask_idx;
   logic [RB-1:0]           row_mask;
   logic [AW-1:0]           offset;
   logic [DW:0]             free_end;

   cba_ram #(
      .WIDTH(RB),
      .DEPTH(ROWS)
   ) u_map (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // first-fit over one row, carrying the current run from earlier rows
   always_comb begin
      scan_run   = run_ff;
      scan_start = start_ff;
      scan_found = 1'b0;
      scan_idx   = '0;
      for (int j = 0; j < RB; j++) begin
         scan_idx = {row_ff, RS'(j)};
         if (!scan_found && ({1'b0, scan_idx} < BLK_LIM_X)) begin
            if (ram_rdata[j]) begin
               scan_start = BLK_W'(scan_idx + IDX_W'(1));
               scan_run   = '0;
            end else begin
               scan_run = scan_run + CNT_W'(1);
            end
            if (scan_run == need_ff) begin
               scan_found = 1'b1;
            end
         end
      end
   end

   always_comb begin
      mask_idx = '0;
      for (int j = 0; j < RB; j++) begin
         mask_idx    = {row_ff, RS'(j)};
         row_mask[j] = ({1'b0, mask_idx} >= XW'(start_ff)) && ({1'b0, mask_idx} < XW'(end_ff));
      end
   end

   assign offset   = addr_ff - pool_base;
   assign free_end = {1'b0, div_rsp.quotient} + (DW + 1)'(need_ff);

   always_comb begin
      state_in    = state_ff;
      row_in      = row_ff;
      last_row_in = last_row_ff;
      op_in       = op_ff;
      addr_in     = addr_ff;
      need_in     = need_ff;
      run_in      = run_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      prod_in     = prod_ff;
      status_in   = status_ff;
      res_addr_in = res_addr_ff;
      ram_we      = 1'b0;
      ram_addr    = row_ff;
      ram_wdata   = '0;
      div_req     = '0;
      req_ready   = 1'b0;
      result      = '0;

      case (state_ff)
         cba_pkg::S_CLEAR: begin
            ram_we = 1'b1;
            if (row_ff == LAST_ROW) begin
               row_in   = '0;
               state_in = cba_pkg::S_IDLE;
            end else begin
               row_in = row_ff + ROW_AW'(1);
            end
         end
         cba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in            = req_op;
               addr_in          = req_addr;
               status_in        = cba_pkg::STATUS_OK;
               res_addr_in      = '0;
               div_req.start    = 1'b1;
               div_req.dividend = DW'(req_size) + DW'(BLOCK_BYTES - 1);
               state_in         = cba_pkg::S_DIV_SIZE;
            end
         end
         cba_pkg::S_DIV_SIZE: begin
            if (div_rsp.done) begin
               need_in  = CNT_W'(div_rsp.quotient);
               state_in = cba_pkg::S_EVAL;
            end
         end
         cba_pkg::S_EVAL: begin
            if (op_ff == cba_pkg::OP_ALLOC) begin
               if (need_ff == '0) begin
                  res_addr_in = pool_base;
                  state_in    = cba_pkg::S_DONE;
               end else if (SW'(need_ff) > BLK_LIM_S) begin
                  status_in = cba_pkg::STATUS_NO_SPACE;
                  state_in  = cba_pkg::S_DONE;
               end else begin
                  run_in   = '0;
                  start_in = '0;
                  row_in   = '0;
                  state_in = cba_pkg::S_SCAN_RD;
               end
            end else begin
               if ((addr_ff < pool_base) || (offset >= POOL_BYTES)) begin
                  status_in = cba_pkg::STATUS_BAD_ADDR;
                  state_in  = cba_pkg::S_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = offset;
                  state_in         = cba_pkg::S_DIV_ADDR;
               end
            end
         end
         cba_pkg::S_DIV_ADDR: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder != '0) begin
                  status_in = cba_pkg::STATUS_BAD_ADDR;
                  state_in  = cba_pkg::S_DONE;
               end else if (free_end > BLK_LIM_D) begin
                  status_in = cba_pkg::STATUS_PAST_END;
                  state_in  = cba_pkg::S_DONE;
               end else if (need_ff == '0) begin
                  state_in = cba_pkg::S_DONE;
               end else begin
                  start_in = BLK_W'(div_rsp.quotient);
                  end_in   = BLK_W'(free_end);
                  state_in = cba_pkg::S_ADD;
               end
            end
         end
         cba_pkg::S_SCAN_RD: begin
            state_in = cba_pkg::S_SCAN;
         end
         cba_pkg::S_SCAN: begin
            // read of the next row overlaps the search of this one
            ram_addr = row_ff + ROW_AW'(1);
            run_in   = scan_run;
            start_in = scan_start;
            if (scan_found) begin
               state_in = cba_pkg::S_MUL;
            end else if (row_ff == LAST_ROW) begin
               status_in = cba_pkg::STATUS_NO_SPACE;
               state_in  = cba_pkg::S_DONE;
            end else begin
               row_in = row_ff + ROW_AW'(1);
            end
         end
         cba_pkg::S_MUL: begin
            prod_in  = AW'(start_ff) * BB_A;
            end_in   = BLK_W'(SW'(start_ff) + SW'(need_ff));
            state_in = cba_pkg::S_ADD;
         end
         cba_pkg::S_ADD: begin
            if (op_ff == cba_pkg::OP_ALLOC) begin
               res_addr_in = pool_base + prod_ff;
            end
            row_in      = ROW_AW'(start_ff >> RS);
            last_row_in = ROW_AW'((end_ff - BLK_W'(1)) >> RS);
            state_in    = cba_pkg::S_RMW_RD;
         end
         cba_pkg::S_RMW_RD: begin
            state_in = cba_pkg::S_RMW_WR;
         end
         cba_pkg::S_RMW_WR: begin
            ram_we = 1'b1;
            if (op_ff == cba_pkg::OP_ALLOC) begin
               ram_wdata = ram_rdata | row_mask;
            end else begin
               ram_wdata = ram_rdata & ~row_mask;
            end
            if (row_ff == last_row_ff) begin
               state_in = cba_pkg::S_DONE;
            end else begin
               row_in   = row_ff + ROW_AW'(1);
               state_in = cba_pkg::S_RMW_RD;
            end
         end
         cba_pkg::S_DONE: begin
            if (out_free) begin
               result.valid   = 1'b1;
               result.status  = status_ff;
               result.address = res_addr_ff;
               state_in       = cba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cba_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cba_pkg::S_CLEAR;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
      end
      last_row_ff <= last_row_in;
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      need_ff     <= need_in;
      run_ff      <= run_in;
      start_ff    <= start_in;
      end_ff      <= end_in;
      prod_ff     <= prod_in;
      status_ff   <= status_in;
      res_addr_ff <= res_addr_in;
   end

   a_result_then_idle: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> (state_ff == cba_pkg::S_IDLE))
      else $error("sequencer did not return to idle after a result");

   a_scan_read_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cba_pkg::S_SCAN || state_ff == cba_pkg::S_SCAN_RD) |-> !ram_we)
      else $error("map written during scan");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == cba_pkg::S_DIV_SIZE || state_ff == cba_pkg::S_DIV_ADDR))
      else $error("divider finished outside a divide state");

   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.status != cba_pkg::STATUS_OK) |-> (result.address == '0))
      else $error("failed request returned a nonzero address");

endmodule

// ===== dv/testbench.sv =====
// Testbench for the block allocator: request/result streams checked against a first-fit predictor.
`timescale 1ns / 1ps
module testbench;

   localparam int BLK_COUNT = cba_pkg::BLOCK_COUNT_DEF;
   localparam int BLK_BYTES = cba_pkg::BLOCK_BYTES_DEF;
   localparam int POOL_BYTES = BLK_COUNT * BLK_BYTES;
   localparam int PHASE_ITEMS = 264;
   localparam int TAIL_CYCLES = 2000;
   localparam longint LIMIT_NS = 200_000_000;
   localparam logic [cba_pkg::CSR_AW-1:0] POOL_BASE_ADDR = {cba_pkg::CSR_IDX_POOL_BASE, 2'b00};

   typedef struct packed {
      cba_pkg::cba_op_type op;
      logic [15:0]         size_bytes;
      logic [31:0]         free_address;
   } alloc_request_type;

   typedef struct packed {
      cba_pkg::cba_status_type status;
      logic [31:0]             address;
   } alloc_outcome_type;

   typedef struct packed {
      logic [15:0] first_block;
      logic [15:0] size_bytes;
   } live_region_type;

   logic                       clock;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [47:0]                req_tdata;   // size_bytes[15:0], free_address[47:16]
   logic                       req_tuser;   // operation[0]
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [39:0]                rsp_tdata;   // status[1:0], alloc_address[33:2], zero
   logic                       csr_psel;
   logic                       csr_penable;
   logic                       csr_pwrite;
   logic [cba_pkg::CSR_AW-1:0] csr_paddr;
   logic [31:0]                csr_pwdata;
   logic [31:0]                csr_prdata;
   logic                       csr_pready;

   // predictor state
   bit          block_in_use [BLK_COUNT];
   logic [31:0] pool_base_setting;
   live_region_type live_regions [$];

   alloc_request_type request_backlog [$];
   alloc_outcome_type pending_outcomes [$];
   int  queued_count;
   int  accepted_count;
   int  error_count;
   bit  req_fire;
   bit  rsp_fire;
   bit  req_idle_on;
   bit  rsp_idle_on;
   int  req_wait;
   int  rsp_wait;

   contiguous_block_allocator_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
   endtask

   // first-fit allocate / range free on the shadow map
   function automatic alloc_outcome_type predict_outcome(alloc_request_type rq);
      alloc_outcome_type res;
      int need;
      int run;
      int first;
      logic [31:0] offset;
      need = (int'(rq.size_bytes) + BLK_BYTES - 1) / BLK_BYTES;
      res.status = cba_pkg::STATUS_OK;
      res.address = '0;
      if (rq.op == cba_pkg::OP_ALLOC) begin
         if (need == 0) begin
            res.address = pool_base_setting;
         end else begin
            run = 0;
            first = 0;
            for (int i = 0; i < BLK_COUNT && run < need; i++) begin
               if (block_in_use[i]) begin
                  first = i + 1;
                  run = 0;
               end else begin
                  run++;
               end
            end
            if (run < need) begin
               res.status = cba_pkg::STATUS_NO_SPACE;
            end else begin
               for (int i = first; i < first + need; i++) block_in_use[i] = 1'b1;
               res.address = pool_base_setting + 32'(first * BLK_BYTES);
               live_regions.push_back('{16'(first), rq.size_bytes});
            end
         end
      end else if (rq.free_address < pool_base_setting) begin
         res.status = cba_pkg::STATUS_BAD_ADDR;
      end else begin
         offset = rq.free_address - pool_base_setting;
         if (offset >= 32'(POOL_BYTES) || offset % BLK_BYTES != 0) begin
            res.status = cba_pkg::STATUS_BAD_ADDR;
         end else begin
            first = int'(offset / BLK_BYTES);
            if (first + need > BLK_COUNT) begin
               res.status = cba_pkg::STATUS_PAST_END;
            end else begin
               for (int i = first; i < first + need; i++) block_in_use[i] = 1'b0;
            end
         end
      end
      return res;
   endfunction

   // request driver
   always @(negedge clock) begin
      alloc_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_fire)) begin
         if (req_tvalid) req_wait = req_idle_on ? $urandom_range(0, 3) : 0;
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            item = request_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {item.free_address, item.size_bytes};
            req_tuser <= item.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result ready driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) rsp_wait = rsp_idle_on ? $urandom_range(0, 3) : 0;
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      alloc_request_type taken;
      alloc_outcome_type want;
      req_fire = !reset && req_tvalid && req_tready;
      rsp_fire = !reset && rsp_tvalid && rsp_tready;
      if (req_fire) begin
         taken.op = cba_pkg::cba_op_type'(req_tuser);
         taken.size_bytes = req_tdata[15:0];
         taken.free_address = req_tdata[47:16];
         pending_outcomes.push_back(predict_outcome(taken));
         accepted_count++;
      end
      if (rsp_fire) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("unexpected result", rsp_tdata[33:2], '0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[1:0] != want.status)
               flag_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
            if (rsp_tdata[33:2] != want.address)
               flag_mismatch("alloc_address", rsp_tdata[33:2], want.address);
         end
      end
   end

   task automatic push_request(cba_pkg::cba_op_type op, logic [15:0] size_bytes,
                               logic [31:0] address);
      request_backlog.push_back('{op, size_bytes, address});
      queued_count++;
   endtask

   task automatic await_accepted();
      while (accepted_count != queued_count) @(posedge clock);
   endtask

   task automatic await_drained();
      while (accepted_count != queued_count || pending_outcomes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_pool_base(logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= POOL_BASE_ADDR;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pool_base_setting = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_pool_base();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= POOL_BASE_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata != pool_base_setting)
         flag_mismatch("pool_base readback", csr_prdata, pool_base_setting);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_random_request();
      int pick;
      int idx;
      int blocks;
      live_region_type region;
      logic [15:0] size_bytes;
      logic [31:0] base;
      base = pool_base_setting;
      pick = $urandom_range(0, 99);
      if (live_regions.size() > 48) pick = 60;   // keep the pool from filling
      if (pick >= 45 && pick < 85 && live_regions.size() == 0) pick = 0;
      if (pick < 45) begin
         size_bytes = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 64))
                                                   : 16'($urandom_range(65, 1024));
         push_request(cba_pkg::OP_ALLOC, size_bytes, $urandom);
      end else if (pick < 85) begin
         idx = $urandom_range(0, live_regions.size() - 1);
         region = live_regions[idx];
         live_regions.delete(idx);
         blocks = (int'(region.size_bytes) + BLK_BYTES - 1) / BLK_BYTES;
         case ($urandom_range(0, 9))
            7, 8:    size_bytes = 16'($urandom_range(region.size_bytes, blocks * BLK_BYTES));
            9:       size_bytes = 16'($urandom_range(1, region.size_bytes));   // partial release
            default: size_bytes = region.size_bytes;
         endcase
         push_request(cba_pkg::OP_FREE, size_bytes,
                      base + 32'(int'(region.first_block) * BLK_BYTES));
      end else begin
         case ($urandom_range(0, 5))
            0: push_request(cba_pkg::OP_ALLOC, 16'($urandom_range(0, 65535)), $urandom);
            1: push_request(cba_pkg::OP_FREE, 16'($urandom_range(0, 65535)), $urandom);
            2: begin
               size_bytes = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                         : 16'($urandom_range(0, 256));
               push_request(cba_pkg::OP_FREE, size_bytes,
                            base + 32'($urandom_range(0, BLK_COUNT - 1) * BLK_BYTES));
            end
            3: push_request(cba_pkg::OP_FREE, 16'($urandom_range(0, 64)),
                            base + 32'($urandom_range(0, BLK_COUNT - 1) * BLK_BYTES)
                                 + 32'($urandom_range(1, BLK_BYTES - 1)));
            4: push_request(cba_pkg::OP_FREE, 16'($urandom_range(0, 64)),
                            base - $urandom_range(1, 4096));
            default: push_request(cba_pkg::OP_FREE, 16'($urandom_range(0, 64)),
                                  base + 32'(POOL_BYTES) + $urandom_range(0, 255));
         endcase
      end
   endtask

   task automatic run_phase(int count);
      int sent;
      int batch;
      sent = 0;
      while (sent < count) begin
         batch = $urandom_range(1, 12);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < batch; k++) queue_random_request();
         sent += batch;
         await_accepted();
      end
   endtask

   initial begin
      logic [31:0] base_plan [6];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      pool_base_setting = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      base_plan[0] = 32'hFFFF_8000;
      base_plan[1] = 32'hFFFF_FFFF;
      base_plan[2] = $urandom & ~32'h7;
      base_plan[3] = $urandom | 32'h1;
      base_plan[4] = 32'h0000_0000;
      base_plan[5] = 32'h8000_0000;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_pool_base();

      // directed pass at the reset base
      push_request(cba_pkg::OP_ALLOC, 16'd0, 32'h0);        // zero size returns the base
      push_request(cba_pkg::OP_ALLOC, 16'd1, 32'h0);
      push_request(cba_pkg::OP_ALLOC, 16'd8, 32'h0);
      push_request(cba_pkg::OP_ALLOC, 16'd9, 32'h0);
      push_request(cba_pkg::OP_ALLOC, 16'hFFFF, 32'h0);     // more blocks than the pool
      push_request(cba_pkg::OP_ALLOC, 16'(POOL_BYTES), 32'h0);
      push_request(cba_pkg::OP_FREE, 16'd8, 32'd8);
      push_request(cba_pkg::OP_ALLOC, 16'd8, 32'h0);        // first fit reuses the hole
      push_request(cba_pkg::OP_FREE, 16'd8, 32'd3);         // misaligned
      push_request(cba_pkg::OP_FREE, 16'd8, 32'(POOL_BYTES));
      push_request(cba_pkg::OP_FREE, 16'd8, 32'hFFFF_FFFF);
      push_request(cba_pkg::OP_FREE, 16'd8, 32'(POOL_BYTES - BLK_BYTES));   // already free
      push_request(cba_pkg::OP_FREE, 16'd9, 32'(POOL_BYTES - BLK_BYTES));   // runs past end
      push_request(cba_pkg::OP_FREE, 16'hFFFF, 32'h0);
      push_request(cba_pkg::OP_FREE, 16'd0, 32'd8);
      push_request(cba_pkg::OP_FREE, 16'(POOL_BYTES), 32'h0);
      push_request(cba_pkg::OP_ALLOC, 16'(POOL_BYTES), 32'h0);   // whole pool
      push_request(cba_pkg::OP_ALLOC, 16'd1, 32'h0);             // pool full
      push_request(cba_pkg::OP_FREE, 16'(POOL_BYTES), 32'h0);
      await_accepted();
      live_regions.delete();
      run_phase(PHASE_ITEMS);

      foreach (base_plan[p]) begin
         await_drained();
         write_pool_base(base_plan[p]);
         check_pool_base();
         push_request(cba_pkg::OP_FREE, 16'(POOL_BYTES), pool_base_setting);
         live_regions.delete();
         run_phase(PHASE_ITEMS);
      end

      await_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
